>>> hdl/matrix_point_set_rect_sum_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the rectangle-sum store
// Shared helpers that wrap clocked concurrent assertions with a reset guard.
// ----------------------------------------------------------------------------
`ifndef MATRIX_POINT_SET_RECT_SUM_TOP_MACROS_SVH
`define MATRIX_POINT_SET_RECT_SUM_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MPSRS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MPSRS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/mpsrs_pkg.sv
// ----------------------------------------------------------------------------
// Rectangle-sum store package
// Sizes, field offsets, request codes, controller states and the command and
// status bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package mpsrs_pkg;

    // Store geometry.
    localparam int MAX_SIZE   = 1024;
    localparam int VALUE_BITS = 32;
    localparam int ROW_W      = $clog2(MAX_SIZE);
    localparam int K_W        = ROW_W + 2;
    localparam int NODE_W     = VALUE_BITS + ROW_W;
    localparam int ADDR_W     = 2 * ROW_W;
    localparam int SIZE_W     = $clog2(MAX_SIZE + 1);

    // Fixed field widths.
    localparam int IDX_W      = 10;
    localparam int CELL_W     = 32;
    localparam int OP_W       = 2;
    localparam int CFG_W      = 11;
    localparam int TOTAL_W    = 64;
    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 64;
    localparam int APB_AW     = 3;

    // Input word layout, lowest bit first.
    localparam int ROW_LOW_LSB  = 0;
    localparam int COL_LOW_LSB  = 10;
    localparam int ROW_HIGH_LSB = 20;
    localparam int COL_HIGH_LSB = 30;
    localparam int CELL_LSB     = 40;

    // Request codes.
    localparam logic [OP_W-1:0] OP_SET   = 2'd0;
    localparam logic [OP_W-1:0] OP_SUM   = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    // Register index and reset value.
    localparam logic             REG_MATRIX_SIZE   = 1'b0;
    localparam logic [CFG_W-1:0] MATRIX_SIZE_RESET = 11'd1024;

    // Controller states.
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_ROW_START,
        ST_WALK_A,
        ST_WALK_B,
        ST_DELTA,
        ST_UPD_RD,
        ST_UPD_WR,
        ST_RESULT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic decode;
        logic row_start;
        logic next_row;
        logic load_kb;
        logic walk_rd;
        logic walk_sub;
        logic delta;
        logic upd_rd;
        logic upd_wr;
        logic result_load;
        logic clr_step;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            bad;
        logic            empty;
        logic            k_zero;
        logic            k_over;
        logic            row_last;
        logic            clr_last;
        logic            out_busy;
    } sts_t;

endpackage

>>> hdl/mpsrs_ctrl.sv
// ----------------------------------------------------------------------------
// Rectangle-sum controller
// Sequences decode, the per-row prefix walks, the point update walk, the
// clearing sweep and the hand-off of each result to the output register.
// ----------------------------------------------------------------------------
`include "matrix_point_set_rect_sum_top_macros.svh"

module mpsrs_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  mpsrs_pkg::sts_t   sts,
    output mpsrs_pkg::cmd_t   cmd
);

    mpsrs_pkg::state_t state_reg;
    mpsrs_pkg::state_t state_next;

    // State register; reset starts the clearing sweep.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mpsrs_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mpsrs_pkg::ST_CLEAR:
            begin
                if (sts.clr_last)
                begin
                    state_next = mpsrs_pkg::ST_IDLE;
                end
            end
            mpsrs_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = mpsrs_pkg::ST_DECODE;
                end
            end
            mpsrs_pkg::ST_DECODE:
            begin
                case (sts.op)
                    mpsrs_pkg::OP_SET:
                        state_next = sts.bad ? mpsrs_pkg::ST_RESULT : mpsrs_pkg::ST_ROW_START;
                    mpsrs_pkg::OP_SUM:
                        state_next = (sts.bad || sts.empty) ? mpsrs_pkg::ST_RESULT
                                                            : mpsrs_pkg::ST_ROW_START;
                    mpsrs_pkg::OP_CLEAR:
                        state_next = mpsrs_pkg::ST_CLEAR;
                    default:
                        state_next = mpsrs_pkg::ST_IDLE;
                endcase
            end
            mpsrs_pkg::ST_ROW_START:
            begin
                state_next = mpsrs_pkg::ST_WALK_A;
            end
            mpsrs_pkg::ST_WALK_A:
            begin
                if (sts.k_zero)
                begin
                    state_next = mpsrs_pkg::ST_WALK_B;
                end
            end
            mpsrs_pkg::ST_WALK_B:
            begin
                if (sts.k_zero)
                begin
                    if (sts.op == mpsrs_pkg::OP_SET)
                    begin
                        state_next = mpsrs_pkg::ST_DELTA;
                    end
                    else if (sts.row_last)
                    begin
                        state_next = mpsrs_pkg::ST_RESULT;
                    end
                    else
                    begin
                        state_next = mpsrs_pkg::ST_ROW_START;
                    end
                end
            end
            mpsrs_pkg::ST_DELTA:
            begin
                state_next = mpsrs_pkg::ST_UPD_RD;
            end
            mpsrs_pkg::ST_UPD_RD:
            begin
                state_next = sts.k_over ? mpsrs_pkg::ST_IDLE : mpsrs_pkg::ST_UPD_WR;
            end
            mpsrs_pkg::ST_UPD_WR:
            begin
                state_next = mpsrs_pkg::ST_UPD_RD;
            end
            mpsrs_pkg::ST_RESULT:
            begin
                if (!sts.out_busy)
                begin
                    state_next = mpsrs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mpsrs_pkg::ST_IDLE;
            end
        endcase
    end

    // Output logic: one command bundle per state.
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            mpsrs_pkg::ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
            end
            mpsrs_pkg::ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            mpsrs_pkg::ST_DECODE:
            begin
                cmd.decode = 1'b1;
            end
            mpsrs_pkg::ST_ROW_START:
            begin
                cmd.row_start = 1'b1;
            end
            mpsrs_pkg::ST_WALK_A:
            begin
                cmd.walk_rd = !sts.k_zero;
                cmd.load_kb = sts.k_zero;
            end
            mpsrs_pkg::ST_WALK_B:
            begin
                cmd.walk_rd  = !sts.k_zero;
                cmd.walk_sub = 1'b1;
                cmd.next_row = sts.k_zero && (sts.op != mpsrs_pkg::OP_SET) && !sts.row_last;
            end
            mpsrs_pkg::ST_DELTA:
            begin
                cmd.delta = 1'b1;
            end
            mpsrs_pkg::ST_UPD_RD:
            begin
                cmd.upd_rd = !sts.k_over;
            end
            mpsrs_pkg::ST_UPD_WR:
            begin
                cmd.upd_wr = 1'b1;
            end
            mpsrs_pkg::ST_RESULT:
            begin
                cmd.result_load = !sts.out_busy;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    // Checks on the sequencing.
    `MPSRS_ASSERT_NEXT(a_accept_decodes, clk, rst_n, in_valid && in_ready,
        state_reg == mpsrs_pkg::ST_DECODE, "accepted word was not decoded next")
    `MPSRS_ASSERT_NOW(a_result_slot_free, clk, rst_n, cmd.result_load, !sts.out_busy,
        "result loaded while output register still holds a word")
    `MPSRS_ASSERT_NOW(a_walk_read_nonzero, clk, rst_n, cmd.walk_rd, !sts.k_zero,
        "prefix walk read issued at node zero")
    `MPSRS_ASSERT_NOW(a_update_in_range, clk, rst_n, cmd.upd_rd || cmd.upd_wr, !sts.k_over,
        "update walk touched a node beyond the tree")

endmodule

>>> hdl/mpsrs_dp.sv
// ----------------------------------------------------------------------------
// Rectangle-sum datapath
// Holds the request, the node memory of per-row sum trees, the walk index,
// the accumulator, the clearing sweep counter and the output register.
// ----------------------------------------------------------------------------
module mpsrs_dp
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  mpsrs_pkg::cmd_t                      cmd,
    input  logic [mpsrs_pkg::IN_DATA_W-1:0]      in_tdata,
    input  logic [mpsrs_pkg::OP_W-1:0]           in_tuser,
    input  logic [mpsrs_pkg::SIZE_W-1:0]         size_eff,
    input  logic                                 out_ready,
    output mpsrs_pkg::sts_t                      sts,
    output logic                                 out_valid,
    output logic [mpsrs_pkg::TOTAL_W-1:0]        out_total,
    output logic                                 out_bad
);

    localparam int DEPTH = 1 << mpsrs_pkg::ADDR_W;

    // Request fields.
    logic [mpsrs_pkg::OP_W-1:0]       op_reg;
    logic [mpsrs_pkg::IDX_W-1:0]      r0_reg;
    logic [mpsrs_pkg::IDX_W-1:0]      c0_reg;
    logic [mpsrs_pkg::IDX_W-1:0]      r1_reg;
    logic [mpsrs_pkg::IDX_W-1:0]      c1_reg;
    logic [mpsrs_pkg::VALUE_BITS-1:0] val_reg;

    // Walk and arithmetic state.
    logic [mpsrs_pkg::IDX_W-1:0]      row_reg;
    logic [mpsrs_pkg::K_W-1:0]        k_reg;
    logic [mpsrs_pkg::K_W-1:0]        k_next;
    logic [mpsrs_pkg::TOTAL_W-1:0]    acc_reg;
    logic [mpsrs_pkg::TOTAL_W-1:0]    acc_next;
    logic [mpsrs_pkg::NODE_W-1:0]     delta_reg;
    logic                             bad_reg;
    logic                             rd_acc_reg;
    logic                             rd_sub_reg;
    logic [mpsrs_pkg::ADDR_W-1:0]     clr_addr_reg;

    // Output register.
    logic                             out_valid_reg;
    logic [mpsrs_pkg::TOTAL_W-1:0]    out_total_reg;
    logic                             out_bad_reg;

    // Node memory.
    logic [mpsrs_pkg::NODE_W-1:0]     node_mem [0:DEPTH-1];
    logic [mpsrs_pkg::NODE_W-1:0]     rdata_reg;

    logic                             bad_set;
    logic                             bad_sum;
    logic [mpsrs_pkg::IDX_W-1:0]      col_end;
    logic [mpsrs_pkg::K_W-1:0]        k_m1;
    logic [mpsrs_pkg::K_W-1:0]        k_low;
    logic [mpsrs_pkg::ADDR_W-1:0]     addr_k;
    logic                             mem_we;
    logic                             mem_re;
    logic [mpsrs_pkg::ADDR_W-1:0]     mem_waddr;
    logic [mpsrs_pkg::NODE_W-1:0]     mem_wdata;
    logic [mpsrs_pkg::TOTAL_W-1:0]    node_ext;
    logic [mpsrs_pkg::NODE_W-1:0]     val_ext;

    // Index checks against the size in effect.
    always_comb
    begin
        bad_set = (32'(r0_reg) >= 32'(size_eff)) || (32'(c0_reg) >= 32'(size_eff));
        bad_sum = bad_set || (32'(r1_reg) >= 32'(size_eff)) || (32'(c1_reg) >= 32'(size_eff));
    end

    // Walk index arithmetic and node address.
    always_comb
    begin
        col_end = (op_reg == mpsrs_pkg::OP_SUM) ? c1_reg : c0_reg;
        k_m1    = k_reg - mpsrs_pkg::K_W'(1);
        k_low   = k_reg & (~k_reg + mpsrs_pkg::K_W'(1));
        addr_k  = {mpsrs_pkg::ROW_W'(row_reg), k_m1[mpsrs_pkg::ROW_W-1:0]};
    end

    // Status bundle.
    always_comb
    begin
        sts.op       = op_reg;
        sts.bad      = (op_reg == mpsrs_pkg::OP_SUM) ? bad_sum : bad_set;
        sts.empty    = (r0_reg > r1_reg) || (c0_reg > c1_reg);
        sts.k_zero   = (k_reg == '0);
        sts.k_over   = (32'(k_reg) > mpsrs_pkg::MAX_SIZE);
        sts.row_last = (row_reg == r1_reg);
        sts.clr_last = &clr_addr_reg;
        sts.out_busy = out_valid_reg && !out_ready;
    end

    // Request capture at acceptance.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg  <= in_tuser;
            r0_reg  <= in_tdata[mpsrs_pkg::ROW_LOW_LSB  +: mpsrs_pkg::IDX_W];
            c0_reg  <= in_tdata[mpsrs_pkg::COL_LOW_LSB  +: mpsrs_pkg::IDX_W];
            r1_reg  <= in_tdata[mpsrs_pkg::ROW_HIGH_LSB +: mpsrs_pkg::IDX_W];
            c1_reg  <= in_tdata[mpsrs_pkg::COL_HIGH_LSB +: mpsrs_pkg::IDX_W];
            val_reg <= in_tdata[mpsrs_pkg::CELL_LSB     +: mpsrs_pkg::VALUE_BITS];
        end
    end

    // Next walk index: prefix walks strip the lowest set bit, the update
    // walk adds it.
    always_comb
    begin
        k_next = k_reg;
        if (cmd.row_start)
        begin
            k_next = mpsrs_pkg::K_W'(col_end) + mpsrs_pkg::K_W'(1);
        end
        else if (cmd.load_kb)
        begin
            k_next = mpsrs_pkg::K_W'(c0_reg);
        end
        else if (cmd.walk_rd)
        begin
            k_next = k_reg & k_m1;
        end
        else if (cmd.delta)
        begin
            k_next = mpsrs_pkg::K_W'(c0_reg) + mpsrs_pkg::K_W'(1);
        end
        else if (cmd.upd_wr)
        begin
            k_next = k_reg + k_low;
        end
    end

    // Sign extensions of a node and of the new cell value.
    always_comb
    begin
        node_ext = {{(mpsrs_pkg::TOTAL_W - mpsrs_pkg::NODE_W){rdata_reg[mpsrs_pkg::NODE_W-1]}},
                    rdata_reg};
        val_ext  = {{(mpsrs_pkg::NODE_W - mpsrs_pkg::VALUE_BITS){val_reg[mpsrs_pkg::VALUE_BITS-1]}},
                    val_reg};
    end

    // Accumulator: cleared at decode, takes each walk read in the cycle after it is issued.
    always_comb
    begin
        acc_next = acc_reg;
        if (cmd.decode)
        begin
            acc_next = '0;
        end
        else if (rd_acc_reg)
        begin
            acc_next = rd_sub_reg ? (acc_reg - node_ext) : (acc_reg + node_ext);
        end
    end

    // Walk registers.
    always_ff @(posedge clk)
    begin
        k_reg   <= k_next;
        acc_reg <= acc_next;
        if (cmd.decode)
        begin
            row_reg <= r0_reg;
            bad_reg <= sts.bad;
        end
        else if (cmd.next_row)
        begin
            row_reg <= row_reg + mpsrs_pkg::IDX_W'(1);
        end
        if (cmd.delta)
        begin
            delta_reg <= val_ext - acc_reg[mpsrs_pkg::NODE_W-1:0];
        end
    end

    // Read tracking and clearing sweep counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_acc_reg   <= 1'b0;
            rd_sub_reg   <= 1'b0;
            clr_addr_reg <= '0;
        end
        else
        begin
            rd_acc_reg <= cmd.walk_rd;
            rd_sub_reg <= cmd.walk_sub;
            if (cmd.clr_step)
            begin
                clr_addr_reg <= clr_addr_reg + mpsrs_pkg::ADDR_W'(1);
            end
        end
    end

    // Memory port control: the sweep writes zeros, the update writes node
    // plus delta.
    always_comb
    begin
        mem_re    = cmd.walk_rd || cmd.upd_rd;
        mem_we    = cmd.clr_step || cmd.upd_wr;
        mem_waddr = cmd.clr_step ? clr_addr_reg : addr_k;
        mem_wdata = cmd.clr_step ? '0 : (rdata_reg + delta_reg);
    end

    // Node memory with registered read.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            node_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= node_mem[addr_k];
        end
    end

    // Output register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= cmd.result_load || (out_valid_reg && !out_ready);
        end
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (cmd.result_load)
        begin
            out_total_reg <= acc_reg;
            out_bad_reg   <= bad_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_total = out_total_reg;
    assign out_bad   = out_bad_reg;

endmodule

>>> hdl/matrix_point_set_rect_sum_top.sv
// ----------------------------------------------------------------------------
// Rectangle-sum store, top level
// Square matrix of signed cells kept as one prefix-sum tree per row, with
// set, rectangle sum and clear requests and an APB size register.
// ----------------------------------------------------------------------------
// A sum walks each row from row_low to row_high, adding the prefix up to col_high and
// subtracting the prefix below col_low, then waits until the output register is free.
// A set reads its old cell the same way, then adds the difference along the update nodes.
// One request is in flight at a time; the node memory does one access per cycle.
// Reset and every clear request start a clearing pass over all 2^20 nodes, one node per
// cycle, during which no word is accepted; register writes go on as ever.
module matrix_point_set_rect_sum_top
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Request stream.
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // s_tdata: row_low[9:0], col_low[19:10], row_high[29:20], col_high[39:30],
    // cell_value[71:40]
    input  logic [mpsrs_pkg::IN_DATA_W-1:0]      s_tdata,
    // s_tuser: op[1:0]
    input  logic [mpsrs_pkg::OP_W-1:0]           s_tuser,
    // Result stream.
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // m_tdata: total[63:0]
    output logic [mpsrs_pkg::OUT_DATA_W-1:0]     m_tdata,
    // m_tuser: bad_index[0]
    output logic                                 m_tuser,
    // Configuration port.
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [mpsrs_pkg::APB_AW-1:0]         paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready
);

    logic [mpsrs_pkg::CFG_W-1:0]  matrix_size_reg;
    logic [mpsrs_pkg::SIZE_W-1:0] size_eff;
    logic                         cfg_write;
    mpsrs_pkg::cmd_t              cmd;
    mpsrs_pkg::sts_t              sts;

    // Register write decode; the word index is the address divided by four.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[2] == mpsrs_pkg::REG_MATRIX_SIZE);

    // Matrix size register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            matrix_size_reg <= mpsrs_pkg::MATRIX_SIZE_RESET;
        end
        else if (cfg_write)
        begin
            matrix_size_reg <= pwdata[mpsrs_pkg::CFG_W-1:0];
        end
    end

    // Register read.
    assign prdata = (paddr[2] == mpsrs_pkg::REG_MATRIX_SIZE) ? 32'(matrix_size_reg) : 32'd0;

    // Size in effect is clipped to the store's capacity.
    assign size_eff = (32'(matrix_size_reg) > mpsrs_pkg::MAX_SIZE)
                      ? mpsrs_pkg::SIZE_W'(mpsrs_pkg::MAX_SIZE)
                      : mpsrs_pkg::SIZE_W'(matrix_size_reg);

    // Controller.
    mpsrs_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Datapath.
    mpsrs_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_tdata  (s_tdata),
        .in_tuser  (s_tuser),
        .size_eff  (size_eff),
        .out_ready (m_tready),
        .sts       (sts),
        .out_valid (m_tvalid),
        .out_total (m_tdata),
        .out_bad   (m_tuser)
    );

endmodule

>>> verif/tb_matrix_point_set_rect_sum_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the rectangle-sum store
// Drives set, sum, clear and unused requests over the request stream and
// changes the matrix size over APB between phases. A cell-level tracker
// predicts every total and bad-index flag, and the result stream is checked
// word by word under random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_matrix_point_set_rect_sum_top;

    localparam logic [mpsrs_pkg::OP_W-1:0] OP_UNUSED     = 2'd3;
    localparam int                         SETTLE_CYCLES = 200;
    localparam int                         IDLE_LIMIT    = 5_000_000;

    // Expected response for one sum or rejected request.
    typedef struct {
        logic [mpsrs_pkg::TOTAL_W-1:0] total;
        logic                          bad_index;
    } sum_result_t;

    // Tracks every written cell and predicts the totals that the store returns.
    class cell_sum_tracker;
        logic [mpsrs_pkg::CFG_W-1:0]   size_reg;
        logic [mpsrs_pkg::TOTAL_W-1:0] cells[int];
        sum_result_t                   pending_totals[$];
        int                            mismatches;
        int                            n_set;
        int                            n_sum;
        int                            n_clear;
        int                            n_ignored;
        int                            n_checked;
        int                            n_bad;

        function new();
            size_reg   = mpsrs_pkg::MATRIX_SIZE_RESET;
            mismatches = 0;
            n_set      = 0;
            n_sum      = 0;
            n_clear    = 0;
            n_ignored  = 0;
            n_checked  = 0;
            n_bad      = 0;
        endfunction

        task report_mismatch(string what);
            $display("[%0t] mismatch: %s", $realtime, what);
            mismatches++;
        endtask

        // Updates the cell copy for one accepted request and queues its result.
        function void note_request(logic [mpsrs_pkg::OP_W-1:0] op,
                                   logic [mpsrs_pkg::IDX_W-1:0] r0,
                                   logic [mpsrs_pkg::IDX_W-1:0] c0,
                                   logic [mpsrs_pkg::IDX_W-1:0] r1,
                                   logic [mpsrs_pkg::IDX_W-1:0] c1,
                                   logic [mpsrs_pkg::CELL_W-1:0] val);
            int unsigned                   n;
            int                            r;
            int                            c;
            logic [mpsrs_pkg::TOTAL_W-1:0] acc;
            sum_result_t                   res;
            n = (size_reg > mpsrs_pkg::MAX_SIZE) ? mpsrs_pkg::MAX_SIZE : size_reg;
            res.total     = '0;
            res.bad_index = 1'b1;
            case (op)
                mpsrs_pkg::OP_SET:
                begin
                    n_set++;
                    if (r0 >= n || c0 >= n)
                        pending_totals.push_back(res);
                    else
                        cells[r0 * mpsrs_pkg::MAX_SIZE + c0] =
                            {{(mpsrs_pkg::TOTAL_W-mpsrs_pkg::CELL_W){val[mpsrs_pkg::CELL_W-1]}},
                             val};
                end
                mpsrs_pkg::OP_SUM:
                begin
                    n_sum++;
                    if (r0 >= n || c0 >= n || r1 >= n || c1 >= n)
                    begin
                        pending_totals.push_back(res);
                    end
                    else
                    begin
                        acc = '0;
                        foreach (cells[key])
                        begin
                            r = key / mpsrs_pkg::MAX_SIZE;
                            c = key % mpsrs_pkg::MAX_SIZE;
                            if (r >= r0 && r <= r1 && c >= c0 && c <= c1)
                                acc += cells[key];
                        end
                        res.total     = acc;
                        res.bad_index = 1'b0;
                        pending_totals.push_back(res);
                    end
                end
                mpsrs_pkg::OP_CLEAR:
                begin
                    n_clear++;
                    cells.delete();
                end
                default:
                begin
                    n_ignored++;
                end
            endcase
        endfunction

        // Compares one result word with the oldest expected total.
        task check_total(logic [mpsrs_pkg::TOTAL_W-1:0] total, logic bad_index);
            sum_result_t exp_res;
            if (pending_totals.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result total=%0d bad=%0b",
                                          $signed(total), bad_index));
                return;
            end
            exp_res = pending_totals.pop_front();
            n_checked++;
            if (exp_res.bad_index)
                n_bad++;
            if (total !== exp_res.total)
                report_mismatch($sformatf("total %0d, expected %0d",
                                          $signed(total), $signed(exp_res.total)));
            if (bad_index !== exp_res.bad_index)
                report_mismatch($sformatf("bad_index %0b, expected %0b",
                                          bad_index, exp_res.bad_index));
        endtask
    endclass

    logic                             clk      = 1'b0;
    logic                             rst_n    = 1'b0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [mpsrs_pkg::IN_DATA_W-1:0]  s_tdata  = '0;
    logic [mpsrs_pkg::OP_W-1:0]       s_tuser  = '0;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [mpsrs_pkg::OUT_DATA_W-1:0] m_tdata;
    logic                             m_tuser;
    logic                             psel     = 1'b0;
    logic                             penable  = 1'b0;
    logic                             pwrite   = 1'b0;
    logic [mpsrs_pkg::APB_AW-1:0]     paddr    = '0;
    logic [31:0]                      pwdata   = '0;
    logic [31:0]                      prdata;
    logic                             pready;

    cell_sum_tracker tracker = new();

    int burst_left   = 0;
    int idle_cycles  = 0;
    int stall_mode   = 0;
    int stall_left   = 0;
    int stall_phase  = 0;
    int size_writes  = 0;

    matrix_point_set_rect_sum_top dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #6 clk = ~clk;

    // Receiver: switches between always ready, coin flips, rare ready and
    // a square wave of stalls.
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(20, 300);
        end
        else
        begin
            stall_left <= stall_left - 1;
        end
        stall_phase <= stall_phase + 1;
        case (stall_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            2:       m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= stall_phase[3];
        endcase
    end

    // Every accepted result word goes to the tracker.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            tracker.check_total(m_tdata, m_tuser);
    end

    // Watchdog: ends the run after a long stretch with no word moving.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with no word moving.", idle_cycles);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Sends one request word, opening a new burst after a random gap.
    task automatic push_request(input logic [mpsrs_pkg::OP_W-1:0] op,
                                input logic [mpsrs_pkg::IDX_W-1:0] r0,
                                input logic [mpsrs_pkg::IDX_W-1:0] c0,
                                input logic [mpsrs_pkg::IDX_W-1:0] r1,
                                input logic [mpsrs_pkg::IDX_W-1:0] c1,
                                input logic [mpsrs_pkg::CELL_W-1:0] val);
        int                              gap;
        logic [mpsrs_pkg::IN_DATA_W-1:0] word;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        word = '0;
        word[mpsrs_pkg::ROW_LOW_LSB  +: mpsrs_pkg::IDX_W]  = r0;
        word[mpsrs_pkg::COL_LOW_LSB  +: mpsrs_pkg::IDX_W]  = c0;
        word[mpsrs_pkg::ROW_HIGH_LSB +: mpsrs_pkg::IDX_W]  = r1;
        word[mpsrs_pkg::COL_HIGH_LSB +: mpsrs_pkg::IDX_W]  = c1;
        word[mpsrs_pkg::CELL_LSB     +: mpsrs_pkg::CELL_W] = val;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= word;
        do @(posedge clk); while (!s_tready);
        burst_left--;
        tracker.note_request(op, r0, c0, r1, c1, val);
    endtask

    // Waits until every expected result is back and the store has gone quiet.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (tracker.pending_totals.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes the size register, then reads it back.
    task automatic write_size(input logic [mpsrs_pkg::CFG_W-1:0] value);
        logic [31:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= mpsrs_pkg::APB_AW'(4 * mpsrs_pkg::REG_MATRIX_SIZE);
        pwdata  <= {{(32-mpsrs_pkg::CFG_W){1'b0}}, value};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        tracker.size_reg = value;
        size_writes++;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== {{(32-mpsrs_pkg::CFG_W){1'b0}}, value})
            tracker.report_mismatch($sformatf("size register reads %0d, expected %0d",
                                              got, value));
    endtask

    // Index inside the size most of the time, biased to a hot corner so that
    // sums see written cells, and sometimes beyond the size.
    function automatic logic [mpsrs_pkg::IDX_W-1:0] pick_index(input int unsigned n);
        int roll;
        roll = $urandom_range(0, 99);
        if (n == 0)
            return mpsrs_pkg::IDX_W'($urandom_range(0, mpsrs_pkg::MAX_SIZE - 1));
        if (roll < 6 && n < mpsrs_pkg::MAX_SIZE)
            return mpsrs_pkg::IDX_W'($urandom_range(n, mpsrs_pkg::MAX_SIZE - 1));
        if (roll < 55)
            return mpsrs_pkg::IDX_W'($urandom_range(0, ((n < 16) ? n : 16) - 1));
        return mpsrs_pkg::IDX_W'($urandom_range(0, n - 1));
    endfunction

    // Far corner of a rectangle; long spans are rare at full size.
    function automatic logic [mpsrs_pkg::IDX_W-1:0] stretch(
        input logic [mpsrs_pkg::IDX_W-1:0] start, input int unsigned n);
        int unsigned span;
        int unsigned stop;
        if (start >= n || ($urandom_range(0, 32) == 0 && n < mpsrs_pkg::MAX_SIZE))
            return pick_index(n);
        if (n >= mpsrs_pkg::MAX_SIZE && $urandom_range(0, 19) != 0)
            span = $urandom_range(0, 15);
        else
            span = $urandom_range(0, n - 1);
        stop = start + span;
        return (stop >= n) ? mpsrs_pkg::IDX_W'(n - 1) : mpsrs_pkg::IDX_W'(stop);
    endfunction

    function automatic logic [mpsrs_pkg::CELL_W-1:0] pick_value();
        case ($urandom_range(0, 5))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return $urandom_range(0, 200) - 100;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // One phase of random sets, sums and unused-code requests at a fixed size.
    task automatic run_random_phase(input logic [mpsrs_pkg::CFG_W-1:0] size_val,
                                    input int items);
        int unsigned                 n;
        int                          done;
        int                          roll;
        logic [mpsrs_pkg::IDX_W-1:0] r0;
        logic [mpsrs_pkg::IDX_W-1:0] c0;
        logic [mpsrs_pkg::IDX_W-1:0] r1;
        logic [mpsrs_pkg::IDX_W-1:0] c1;
        logic [mpsrs_pkg::IDX_W-1:0] tmp;
        n    = (size_val > mpsrs_pkg::MAX_SIZE) ? mpsrs_pkg::MAX_SIZE : size_val;
        done = 0;
        while (done < items)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 4)
            begin
                push_request(OP_UNUSED, mpsrs_pkg::IDX_W'($urandom),
                             mpsrs_pkg::IDX_W'($urandom), mpsrs_pkg::IDX_W'($urandom),
                             mpsrs_pkg::IDX_W'($urandom), $urandom);
            end
            else if (roll < 50)
            begin
                push_request(mpsrs_pkg::OP_SET, pick_index(n), pick_index(n),
                             mpsrs_pkg::IDX_W'($urandom), mpsrs_pkg::IDX_W'($urandom),
                             pick_value());
                done++;
            end
            else
            begin
                r0 = pick_index(n);
                c0 = pick_index(n);
                r1 = stretch(r0, n);
                c1 = stretch(c0, n);
                // Now and then a reversed rectangle, which must sum to zero.
                if ($urandom_range(0, 9) == 0)
                begin
                    tmp = r0;
                    r0  = r1;
                    r1  = tmp;
                end
                if ($urandom_range(0, 9) == 0)
                begin
                    tmp = c0;
                    c0  = c1;
                    c1  = tmp;
                end
                push_request(mpsrs_pkg::OP_SUM, r0, c0, r1, c1, $urandom);
                done++;
            end
        end
    endtask

    initial
    begin
        logic [mpsrs_pkg::CFG_W-1:0] phase_sizes[8];
        phase_sizes = '{11'd8, 11'd1024, 11'd3, 11'd37, 11'd1, 11'd2047, 11'd600, 11'd16};

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Full size: corner cells with extreme values, overwrite, empty ranges.
        write_size(11'd1024);
        push_request(mpsrs_pkg::OP_SET, 10'd0, 10'd0, 10'd0, 10'd0, 32'h7FFF_FFFF);
        push_request(mpsrs_pkg::OP_SET, 10'd1023, 10'd1023, 10'd0, 10'd0, 32'h8000_0000);
        push_request(mpsrs_pkg::OP_SET, 10'd0, 10'd1023, 10'd0, 10'd0, 32'hFFFF_FFFF);
        push_request(mpsrs_pkg::OP_SET, 10'd1023, 10'd0, 10'd0, 10'd0, 32'd12345);
        push_request(mpsrs_pkg::OP_SUM, 10'd0, 10'd0, 10'd1023, 10'd1023, 32'd0);
        push_request(mpsrs_pkg::OP_SET, 10'd0, 10'd0, 10'd1023, 10'd1023, -32'sd5);
        push_request(mpsrs_pkg::OP_SUM, 10'd0, 10'd0, 10'd0, 10'd0, 32'd0);
        push_request(mpsrs_pkg::OP_SUM, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 32'd0);
        push_request(mpsrs_pkg::OP_SUM, 10'd0, 10'd1023, 10'd1023, 10'd1023, 32'd0);
        push_request(mpsrs_pkg::OP_SUM, 10'd5, 10'd0, 10'd2, 10'd10, 32'd0);
        push_request(mpsrs_pkg::OP_SUM, 10'd0, 10'd9, 10'd1023, 10'd3, 32'd0);
        push_request(OP_UNUSED, 10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF, 32'hFFFF_FFFF);

        // Size above the maximum behaves as the maximum.
        settle();
        write_size(11'd2047);
        push_request(mpsrs_pkg::OP_SUM, 10'd0, 10'd0, 10'd1023, 10'd1023, 32'd0);
        push_request(mpsrs_pkg::OP_SET, 10'd512, 10'd700, 10'd0, 10'd0, 32'h1234_5678);

        // Size zero rejects every index.
        settle();
        write_size(11'd0);
        push_request(mpsrs_pkg::OP_SET, 10'd0, 10'd0, 10'd0, 10'd0, 32'd1);
        push_request(mpsrs_pkg::OP_SUM, 10'd0, 10'd0, 10'd0, 10'd0, 32'd0);

        // Size one: single cell, then clear.
        settle();
        write_size(11'd1);
        push_request(mpsrs_pkg::OP_SET, 10'd0, 10'd0, 10'd0, 10'd0, -32'sd9);
        push_request(mpsrs_pkg::OP_SET, 10'd0, 10'd1, 10'd0, 10'd0, 32'd3);
        push_request(mpsrs_pkg::OP_SUM, 10'd0, 10'd0, 10'd0, 10'd1, 32'd0);
        push_request(mpsrs_pkg::OP_SUM, 10'd0, 10'd0, 10'd0, 10'd0, 32'd0);
        push_request(mpsrs_pkg::OP_CLEAR, mpsrs_pkg::IDX_W'($urandom),
                     mpsrs_pkg::IDX_W'($urandom), mpsrs_pkg::IDX_W'($urandom),
                     mpsrs_pkg::IDX_W'($urandom), $urandom);
        push_request(mpsrs_pkg::OP_SUM, 10'd0, 10'd0, 10'd0, 10'd0, 32'd0);

        // Random phases over a spread of sizes.
        foreach (phase_sizes[i])
        begin
            settle();
            write_size(phase_sizes[i]);
            run_random_phase(phase_sizes[i], 32);
        end

        settle();
        $display("Ran %0d set, %0d sum, %0d clear and %0d unused-code requests",
                 tracker.n_set, tracker.n_sum, tracker.n_clear, tracker.n_ignored);
        $display("over %0d size settings; checked %0d result words, %0d flagged as bad index.",
                 size_writes, tracker.n_checked, tracker.n_bad);
        if (tracker.mismatches == 0 && tracker.pending_totals.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hdl
hdl/mpsrs_pkg.sv
hdl/mpsrs_ctrl.sv
hdl/mpsrs_dp.sv
hdl/matrix_point_set_rect_sum_top.sv
verif/tb_matrix_point_set_rect_sum_top.sv
